@@ rtl/sip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sip_pkg;

	// Field widths of the segment coordinates and of the fixed-point result.
	localparam int CoordW = 16;
	localparam int FracW  = 8;
	localparam int OutW   = CoordW + FracW;

	// Difference of two coordinates, products of two differences and the
	// cross-product terms built from two products.
	localparam int DifW = CoordW + 1;
	localparam int PrdW = 2 * DifW;
	localparam int DenW = PrdW + 1;

	// Magnitude of the normalized denominator; the numerator of t lies in
	// [0, denominator] on a hit, so it fits the same width.
	localparam int MagW = DenW - 1;

	// Dividend |v| * tn * 2^FracW and the quotient, which is at most
	// |v| * 2^FracW because tn never exceeds the denominator.
	localparam int NumW = CoordW + MagW + FracW;
	localparam int QuoW = CoordW + FracW;

	// Stages ahead of the divider, divider stages, and the output stage.
	localparam int PreStages = 5;
	localparam int NumStages = PreStages + QuoW + 1;

	// State that travels through the divider stages.
	typedef struct packed {
		logic                     hit;
		logic                     neg_x;
		logic                     neg_y;
		logic signed [CoordW-1:0] px;
		logic signed [CoordW-1:0] py;
		logic [MagW-1:0]          den;
		logic [NumW-1:0]          rem_x;
		logic [NumW-1:0]          rem_y;
		logic [QuoW-1:0]          quo_x;
		logic [QuoW-1:0]          quo_y;
	} div_t;

endpackage

`default_nettype wire

@@ rtl/segment_intersection_point_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// segments  seg_valid / seg_stall     first_start_x .. second_end_y, 16-bit signed each
// result    res_valid / res_stall     hit, cross_x and cross_y, 24-bit signed, 8 fraction bits
//
// Every transaction passes 30 register stages, and a new transaction can enter in every cycle
// while seg_stall is low. Five stages form the differences, products, sign fix and hit test,
// 24 stages are the restoring divider with one quotient bit each, and the last stage adds
// the offset to the start point.
// Reset clears only the valid bits of the stages; payload registers are not reset.
// A stall on the result side holds the full stages, while empty stages keep filling.
module segment_intersection_point_top
	import sip_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     seg_valid,
	output logic                          seg_stall,
	input  wire logic signed [CoordW-1:0] first_start_x,
	input  wire logic signed [CoordW-1:0] first_start_y,
	input  wire logic signed [CoordW-1:0] first_end_x,
	input  wire logic signed [CoordW-1:0] first_end_y,
	input  wire logic signed [CoordW-1:0] second_start_x,
	input  wire logic signed [CoordW-1:0] second_start_y,
	input  wire logic signed [CoordW-1:0] second_end_x,
	input  wire logic signed [CoordW-1:0] second_end_y,
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output logic                          hit,
	output logic signed [OutW-1:0]        cross_x,
	output logic signed [OutW-1:0]        cross_y
);

	// Valid bit of every stage, and the enable of every stage. A stage loads
	// when it is empty or when the stage after it moves on, so bubbles are
	// squeezed out even while the result is stalled.
	logic [NumStages-1:0] stage_vld_q;
	logic [NumStages-1:0] stage_en;

	assign stage_en[NumStages-1] = !stage_vld_q[NumStages-1] || !res_stall;

	for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
		assign stage_en[k] = !stage_vld_q[k] || stage_en[k+1];
	end

	assign seg_stall = !stage_en[0];
	assign res_valid = stage_vld_q[NumStages-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= seg_valid;
			end
			for (int k = 1; k < NumStages; k++) begin
				if (stage_en[k]) begin
					stage_vld_q[k] <= stage_vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: the start point of the first segment and the direction
	// vectors v and w, plus the offset between the two start points.
	logic signed [CoordW-1:0] px_s1, py_s1;
	logic signed [DifW-1:0]   vx_s1, vy_s1, wx_s1, wy_s1, dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			px_s1 <= first_start_x;
			py_s1 <= first_start_y;
			vx_s1 <= DifW'(first_end_x) - DifW'(first_start_x);
			vy_s1 <= DifW'(first_end_y) - DifW'(first_start_y);
			wx_s1 <= DifW'(second_end_x) - DifW'(second_start_x);
			wy_s1 <= DifW'(second_end_y) - DifW'(second_start_y);
			dx_s1 <= DifW'(second_start_x) - DifW'(first_start_x);
			dy_s1 <= DifW'(second_start_y) - DifW'(first_start_y);
		end
	end

	// Stage 2: the six cross-product terms, and the magnitude and sign of v
	// for the scaling of the intersection point.
	logic signed [CoordW-1:0] px_s2, py_s2;
	logic [CoordW-1:0]        mvx_s2, mvy_s2;
	logic                     nvx_s2, nvy_s2;
	logic signed [PrdW-1:0]   vxwy_s2, vywx_s2, dxwy_s2, dywx_s2, dxvy_s2, dyvx_s2;
	logic signed [DifW-1:0]   vx_neg, vy_neg;

	assign vx_neg = -vx_s1;
	assign vy_neg = -vy_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			nvx_s2  <= vx_s1[DifW-1];
			nvy_s2  <= vy_s1[DifW-1];
			mvx_s2  <= vx_s1[DifW-1] ? vx_neg[CoordW-1:0] : vx_s1[CoordW-1:0];
			mvy_s2  <= vy_s1[DifW-1] ? vy_neg[CoordW-1:0] : vy_s1[CoordW-1:0];
			vxwy_s2 <= vx_s1 * wy_s1;
			vywx_s2 <= vy_s1 * wx_s1;
			dxwy_s2 <= dx_s1 * wy_s1;
			dywx_s2 <= dy_s1 * wx_s1;
			dxvy_s2 <= dx_s1 * vy_s1;
			dyvx_s2 <= dy_s1 * vx_s1;
		end
	end

	// Stage 3: denominator and the numerators of t and s.
	logic signed [CoordW-1:0] px_s3, py_s3;
	logic [CoordW-1:0]        mvx_s3, mvy_s3;
	logic                     nvx_s3, nvy_s3;
	logic signed [DenW-1:0]   den_s3, tn_s3, sn_s3;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			px_s3  <= px_s2;
			py_s3  <= py_s2;
			mvx_s3 <= mvx_s2;
			mvy_s3 <= mvy_s2;
			nvx_s3 <= nvx_s2;
			nvy_s3 <= nvy_s2;
			den_s3 <= DenW'(vxwy_s2) - DenW'(vywx_s2);
			tn_s3  <= DenW'(dxwy_s2) - DenW'(dywx_s2);
			sn_s3  <= DenW'(dxvy_s2) - DenW'(dyvx_s2);
		end
	end

	// Stage 4: flip all three signs when the denominator is negative, so
	// that the range test below works against a positive denominator.
	logic signed [CoordW-1:0] px_s4, py_s4;
	logic [CoordW-1:0]        mvx_s4, mvy_s4;
	logic                     nvx_s4, nvy_s4, dnz_s4;
	logic signed [DenW-1:0]   den_s4, tn_s4, sn_s4;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			px_s4  <= px_s3;
			py_s4  <= py_s3;
			mvx_s4 <= mvx_s3;
			mvy_s4 <= mvy_s3;
			nvx_s4 <= nvx_s3;
			nvy_s4 <= nvy_s3;
			dnz_s4 <= (den_s3 != '0);
			if (den_s3[DenW-1]) begin
				den_s4 <= -den_s3;
				tn_s4  <= -tn_s3;
				sn_s4  <= -sn_s3;
			end else begin
				den_s4 <= den_s3;
				tn_s4  <= tn_s3;
				sn_s4  <= sn_s3;
			end
		end
	end

	// Stage 5: hit test, with both parameters inside [0, 1], and the two
	// dividends |v| * tn scaled up by the fraction bits.
	div_t                    div_s5;
	logic [MagW-1:0]         tn_mag;
	logic [CoordW+MagW-1:0]  prod_x, prod_y;

	assign tn_mag = tn_s4[MagW-1:0];
	assign prod_x = mvx_s4 * tn_mag;
	assign prod_y = mvy_s4 * tn_mag;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			div_s5.hit   <= dnz_s4 && !tn_s4[DenW-1] && !sn_s4[DenW-1]
				&& (tn_s4 <= den_s4) && (sn_s4 <= den_s4);
			div_s5.neg_x <= nvx_s4;
			div_s5.neg_y <= nvy_s4;
			div_s5.px    <= px_s4;
			div_s5.py    <= py_s4;
			div_s5.den   <= den_s4[MagW-1:0];
			div_s5.rem_x <= NumW'(prod_x) << FracW;
			div_s5.rem_y <= NumW'(prod_y) << FracW;
			div_s5.quo_x <= '0;
			div_s5.quo_y <= '0;
		end
	end

	// Restoring division, one quotient bit per stage from the top bit down.
	// The dividend is below den * 2^QuoW, so QuoW steps give the full
	// quotient, truncated toward zero.
	div_t div_s [QuoW];
	div_t div_in [QuoW];
	div_t div_nxt [QuoW];

	for (genvar j = 0; j < QuoW; j++) begin : g_div
		localparam int Bit = QuoW - 1 - j;
		logic [NumW-1:0] trial;

		if (j == 0) begin : g_first
			assign div_in[j] = div_s5;
		end else begin : g_next
			assign div_in[j] = div_s[j-1];
		end

		assign trial = NumW'(div_in[j].den) << Bit;

		always_comb begin
			div_nxt[j] = div_in[j];
			if (div_in[j].rem_x >= trial) begin
				div_nxt[j].rem_x      = div_in[j].rem_x - trial;
				div_nxt[j].quo_x[Bit] = 1'b1;
			end
			if (div_in[j].rem_y >= trial) begin
				div_nxt[j].rem_y      = div_in[j].rem_y - trial;
				div_nxt[j].quo_y[Bit] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[PreStages+j]) begin
				div_s[j] <= div_nxt[j];
			end
		end
	end

	// Output stage: restore the sign of the offset and add it to the start
	// point of the first segment. A miss gives a zero point.
	div_t                  fin;
	logic signed [OutW-1:0] off_x, off_y, sum_x, sum_y;
	logic                   hit_s30;
	logic signed [OutW-1:0] cross_x_s30, cross_y_s30;

	assign fin   = div_s[QuoW-1];
	assign off_x = fin.neg_x ? -fin.quo_x : fin.quo_x;
	assign off_y = fin.neg_y ? -fin.quo_y : fin.quo_y;
	assign sum_x = (OutW'(fin.px) << FracW) + off_x;
	assign sum_y = (OutW'(fin.py) << FracW) + off_y;

	always_ff @(posedge clk) begin
		if (stage_en[NumStages-1]) begin
			hit_s30     <= fin.hit;
			cross_x_s30 <= fin.hit ? sum_x : '0;
			cross_y_s30 <= fin.hit ? sum_y : '0;
		end
	end

	assign hit     = hit_s30;
	assign cross_x = cross_x_s30;
	assign cross_y = cross_y_s30;

endmodule

`default_nettype wire
